// ----- src/bilevel_run_length_row_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bilevel run-length row decoder
// Clocked assertion wrappers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef BILEVEL_RUN_LENGTH_ROW_DECODER_CORE_MACROS_SVH
`define BILEVEL_RUN_LENGTH_ROW_DECODER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BILRL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BILRL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- src/bilrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilevel run-length row decoder package
// Field widths, register indexes and the span record shared by the files.
// ----------------------------------------------------------------------------
`default_nettype none

package bilrl_pkg;

   // Geometry limits
   localparam int MaxWidth  = 4096;
   localparam int MaxHeight = 4096;
   localparam int PrefixCap = 11;

   // Field widths
   localparam int CodeW   = 8;
   localparam int LevelW  = 8;
   localparam int RunW    = 13;
   localparam int ColW    = 12;
   localparam int RowW    = 12;
   localparam int CfgW    = 13;
   localparam int CsrAddrW = 2;

   // Port widths: tdata packs level, run, column, row; tuser packs flags
   localparam int TdataW = 48;
   localparam int TuserW = 3;

   // Register indexes
   localparam logic [CsrAddrW-1:0] CsrImageWidth  = 2'd0;
   localparam logic [CsrAddrW-1:0] CsrImageHeight = 2'd1;
   localparam logic [CsrAddrW-1:0] CsrWhiteLevel  = 2'd2;

   // One decoded run
   typedef struct packed {
      logic [LevelW-1:0] pixel_level;
      logic [RunW-1:0]   run_pixels;
      logic [ColW-1:0]   start_column;
      logic [RowW-1:0]   row_index;
      logic              row_complete;
      logic              frame_complete;
      logic              clipped;
   } span_type;

endpackage

`default_nettype wire

// ----- src/bilevel_run_length_row_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Bilevel run-length row decoder core
// Decodes a run-length coded bilevel image into one span per run.
// ----------------------------------------------------------------------------
// Each accepted code byte is shifted through the decoder one bit per cycle,
// most significant bit first, unless a span stall holds the bit loop. The
// byte passes a setup state, the bit states and a hand-over state for its
// last span, and only then is the next byte accepted; a row that ends
// inside the byte drops the remaining bits and goes to the hand-over.
// Spans are handed out through an output register; the decoder stalls
// only while a span finds that register still full: a second span of the
// same byte holds the bit loop, and the last span of a byte holds the
// hand-over state, so the next byte waits. Every span of a byte except the
// last leaves as soon as the next one is found; the last carries
// last_of_byte. The user must write configuration through the csr_ port
// only while the decoder is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module bilevel_run_length_row_decoder_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Configuration write port
   input  wire logic                                 csr_we,
   input  wire logic [bilrl_pkg::CsrAddrW-1:0]       csr_addr,
   input  wire logic [bilrl_pkg::CfgW-1:0]           csr_wdata,
   // Code byte input
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [bilrl_pkg::CodeW-1:0]          req_tdata,  // code_byte
   // Span output
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // pixel_level[7:0], run_pixels[20:8], start_column[32:21], row_index[44:33]
   output logic [bilrl_pkg::TdataW-1:0]              rsp_tdata,
   // row_complete[0], clipped[1], last_of_byte[2]
   output logic [bilrl_pkg::TuserW-1:0]              rsp_tuser,
   output logic                                      rsp_tlast   // frame_complete
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_BITS,
      ST_FLUSH
   } ctl_state_type;

   typedef enum logic [1:0] {
      PH_COLOR  = 2'd0,
      PH_PREFIX = 2'd1,
      PH_VALUE  = 2'd2
   } phase_type;

   // Control and decode state
   ctl_state_type                   state_ff, state_in;
   phase_type                       phase_ff, phase_in;
   logic [bilrl_pkg::CodeW-1:0]     sr_ff, sr_in;
   logic [2:0]                      bit_cnt_ff, bit_cnt_in;
   logic [3:0]                      prefix_ff, prefix_in;
   logic [3:0]                      bits_left_ff, bits_left_in;
   logic [bilrl_pkg::RunW-1:0]      acc_ff, acc_in;
   logic                            color_ff, color_in;
   logic [bilrl_pkg::CfgW-1:0]      col_ff, col_in;
   logic [bilrl_pkg::RowW-1:0]      row_ff, row_in;

   // Configuration
   logic [bilrl_pkg::CfgW-1:0]      width_ff, width_in;
   logic [bilrl_pkg::CfgW-1:0]      height_ff, height_in;
   logic [bilrl_pkg::LevelW-1:0]    white_ff, white_in;

   // Precomputed row geometry
   logic [bilrl_pkg::ColW-1:0]      col_eff_ff, col_eff_in;
   logic [bilrl_pkg::ColW-1:0]      leftm1_ff, leftm1_in;
   logic                            row_last_ff, row_last_in;

   // Pending span and output register
   bilrl_pkg::span_type             pend_ff, pend_in;
   logic                            pend_valid_ff, pend_valid_in;
   bilrl_pkg::span_type             out_ff, out_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_valid_ff, out_valid_in;

   // Combinational helpers
   logic [bilrl_pkg::CfgW-1:0]      w_eff, h_eff, col_clamp, leftm1_full;
   logic [bilrl_pkg::RunW-1:0]      acc_new, cut_len, run_len, col_next;
   logic                            cur_bit, emit, cut, row_done, out_free, hold;
   bilrl_pkg::span_type             new_span;

   // Port drive
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.row_index, out_ff.start_column,
                        out_ff.run_pixels, out_ff.pixel_level};
   assign rsp_tuser  = {out_last_ff, out_ff.clipped, out_ff.row_complete};
   assign rsp_tlast  = out_ff.frame_complete;

   // Effective geometry and run bounds
   always_comb begin
      if (width_ff == '0) begin
         w_eff = 13'd1;
      end else if (width_ff > 13'(bilrl_pkg::MaxWidth)) begin
         w_eff = 13'(bilrl_pkg::MaxWidth);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = 13'd1;
      end else if (height_ff > 13'(bilrl_pkg::MaxHeight)) begin
         h_eff = 13'(bilrl_pkg::MaxHeight);
      end else begin
         h_eff = height_ff;
      end
      col_clamp   = (col_ff >= w_eff) ? (w_eff - 13'd1) : col_ff;
      leftm1_full = w_eff + ~col_clamp;
      col_eff_in  = col_clamp[bilrl_pkg::ColW-1:0];
      leftm1_in   = leftm1_full[bilrl_pkg::ColW-1:0];
      row_last_in = ({1'b0, row_ff} >= (h_eff - 13'd1));
   end

   // Current bit and span completion
   always_comb begin
      cur_bit  = sr_ff[bilrl_pkg::CodeW-1];
      acc_new  = {acc_ff[bilrl_pkg::RunW-2:0], cur_bit};
      emit     = (state_ff == ST_BITS) && (phase_ff == PH_VALUE) && (bits_left_ff == 4'd1);
      cut      = acc_new >  {1'b0, leftm1_ff};
      row_done = acc_new >= {1'b0, leftm1_ff};
      cut_len  = {1'b0, leftm1_ff} + 13'd1;
      run_len  = acc_new + 13'd1;
      col_next = {1'b0, col_eff_ff} + acc_new + 13'd1;
      out_free = !out_valid_ff || rsp_tready;
      hold     = emit && pend_valid_ff && !out_free;

      new_span.pixel_level    = color_ff ? white_ff : '0;
      new_span.run_pixels     = cut ? cut_len : run_len;
      new_span.start_column   = col_eff_ff;
      new_span.row_index      = row_ff;
      new_span.row_complete   = row_done;
      new_span.frame_complete = row_done && row_last_ff;
      new_span.clipped        = cut;
   end

   // Next state
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sr_in         = sr_ff;
      bit_cnt_in    = bit_cnt_ff;
      prefix_in     = prefix_ff;
      bits_left_in  = bits_left_ff;
      acc_in        = acc_ff;
      color_in      = color_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      white_in      = white_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;

      // Take configuration writes
      if (csr_we) begin
         case (csr_addr)
            bilrl_pkg::CsrImageWidth:  width_in  = csr_wdata;
            bilrl_pkg::CsrImageHeight: height_in = csr_wdata;
            bilrl_pkg::CsrWhiteLevel:  white_in  = csr_wdata[bilrl_pkg::LevelW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sr_in    = req_tdata;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            bit_cnt_in = 3'd7;
            state_in   = ST_BITS;
         end
         ST_BITS: begin
            if (!hold) begin
               // Advance one bit
               sr_in      = {sr_ff[bilrl_pkg::CodeW-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - 3'd1;
               unique case (phase_ff)
                  PH_PREFIX: begin
                     if (cur_bit) begin
                        if (prefix_ff < 4'(bilrl_pkg::PrefixCap)) begin
                           prefix_in = prefix_ff + 4'd1;
                        end
                     end else begin
                        bits_left_in = prefix_ff + 4'd2;
                        acc_in       = '0;
                        phase_in     = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     acc_in       = acc_new;
                     bits_left_in = bits_left_ff - 4'd1;
                     if (emit) begin
                        // Push the previous span of this byte out, hold the new one
                        if (pend_valid_ff) begin
                           out_in       = pend_ff;
                           out_last_in  = 1'b0;
                           out_valid_in = 1'b1;
                        end
                        pend_in       = new_span;
                        pend_valid_in = 1'b1;
                        color_in      = !color_ff;
                        prefix_in     = '0;
                        bits_left_in  = '0;
                        acc_in        = '0;
                        if (row_done) begin
                           col_in   = '0;
                           row_in   = row_last_ff ? '0 : (row_ff + 12'd1);
                           phase_in = PH_COLOR;
                        end else begin
                           col_in   = col_next;
                           phase_in = PH_PREFIX;
                        end
                     end
                  end
                  default: begin
                     color_in     = cur_bit;
                     prefix_in    = '0;
                     bits_left_in = '0;
                     acc_in       = '0;
                     phase_in     = PH_PREFIX;
                  end
               endcase
               // Go to the hand-over at the end of the byte, or drop the rest of the byte once the row ends
               if ((bit_cnt_ff == 3'd0) || (emit && row_done)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            // Hand over the last span of the byte
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_COLOR;
         prefix_ff     <= '0;
         bits_left_ff  <= '0;
         acc_ff        <= '0;
         color_ff      <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         width_ff      <= 13'd256;
         height_ff     <= 13'd256;
         white_ff      <= 8'd255;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         prefix_ff     <= prefix_in;
         bits_left_ff  <= bits_left_in;
         acc_ff        <= acc_in;
         color_ff      <= color_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         white_ff      <= white_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      sr_ff       <= sr_in;
      bit_cnt_ff  <= bit_cnt_in;
      col_eff_ff  <= col_eff_in;
      leftm1_ff   <= leftm1_in;
      row_last_ff <= row_last_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

// ----- src/bilrl_checker.sv -----
// ----------------------------------------------------------------------------
// Bilevel run-length row decoder checker
// Port-level checks on the span stream, bound to the decoder core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilevel_run_length_row_decoder_core_macros.svh"

module bilrl_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [bilrl_pkg::TdataW-1:0]    rsp_tdata,
   input  wire logic [bilrl_pkg::TuserW-1:0]    rsp_tuser,
   input  wire logic                            rsp_tlast
);

   // Hold a stalled span
   `BILRL_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "span changed while stalled")

   // A frame ends only with its last row
   `BILRL_ASSERT(a_frame_has_row, rsp_tvalid && rsp_tlast |-> rsp_tuser[0], "frame end without row end")

   // A clipped run always closes its row
   `BILRL_ASSERT(a_clip_ends_row, rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0], "clipped span left row open")

   // A row end drops the rest of the byte, so it is the byte's last span
   `BILRL_ASSERT(a_row_ends_byte, rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2], "span after row end in same byte")

   // No span is empty
   `BILRL_ASSERT(a_run_nonzero, rsp_tvalid |-> rsp_tdata[20:8] != 13'd0, "empty span")

endmodule

bind bilevel_run_length_row_decoder_core bilrl_checker u_bilrl_checker (.*);

`default_nettype wire
